@@ sv/sirt_pkg.sv @@
// shared types, constants and helpers for the strided interval relation test
`default_nettype none
package sirt_pkg;

	localparam int WORD_BITS  = 64;
	localparam int DATA_W     = 64;
	localparam int WIDTH_W    = 7;
	localparam int SCALE_W    = 6;
	localparam int NUM_STAGES = 8;

	typedef struct packed {
		logic [DATA_W-1:0]  first_offset;
		logic [DATA_W-1:0]  first_count;
		logic [SCALE_W-1:0] first_stride_log;
		logic [WIDTH_W-1:0] first_width;
		logic [DATA_W-1:0]  second_offset;
		logic [DATA_W-1:0]  second_count;
		logic [SCALE_W-1:0] second_stride_log;
		logic [WIDTH_W-1:0] second_width;
	} query_t;

	typedef struct packed {
		logic contains;
		logic overlaps;
	} result_t;

	// low n bits set, n of 64 or more gives all ones
	function automatic logic [DATA_W-1:0] low_ones(input logic [WIDTH_W-1:0] n);
		logic [DATA_W-1:0] r;
		if (n >= WIDTH_W'(DATA_W))
			r = '1;
		else
			r = (DATA_W'(1) << n) - DATA_W'(1);
		return r;
	endfunction

endpackage
`default_nettype wire

@@ sv/sirt_core.sv @@
// datapath of the strided interval relation test, eight register stages
`default_nettype none
module sirt_core (
	input  wire logic                          clk,
	input  wire logic [sirt_pkg::NUM_STAGES:1] en,
	input  wire sirt_pkg::query_t              query,
	output sirt_pkg::result_t                  result
);

	localparam int W = sirt_pkg::DATA_W;
	localparam int S = sirt_pkg::SCALE_W;
	localparam int K = sirt_pkg::WIDTH_W;

	typedef struct packed {
		logic [W-1:0] m;
		logic [W-1:0] disp;
		logic [W-1:0] cnt;
		logic [W-1:0] i;
		logic [W-1:0] d;
		logic [S-1:0] s;
	} op_t;

	typedef struct packed {
		logic early;
		logic eval;
		logic mis;
		logic kill;
	} ofl_t;

	function automatic op_t load_op(input logic [W-1:0] off, input logic [W-1:0] cnt,
			input logic [S-1:0] s, input logic [K-1:0] w);
		op_t r;
		logic [K-1:0] wc;
		logic [W-1:0] lim;
		wc = (w > K'(sirt_pkg::WORD_BITS)) ? K'(sirt_pkg::WORD_BITS) : w;
		r.m = sirt_pkg::low_ones(wc);
		r.disp = off & r.m;
		r.cnt = cnt;
		r.s = s;
		lim = r.m >> s;
		if (cnt > lim) begin
			r.i = lim;
			r.d = r.disp & sirt_pkg::low_ones({1'b0, s});
		end else begin
			r.i = cnt;
			r.d = r.disp;
		end
		return r;
	endfunction

	function automatic logic seg_covers(input logic [W-1:0] alo, input logic [W-1:0] aup,
			input logic [W-1:0] blo, input logic [W-1:0] bup, input logic [W-1:0] m);
		logic r;
		if (alo <= aup) begin
			if (blo <= bup)
				r = (alo <= blo) && (aup >= bup);
			else
				r = (alo == '0) && (aup == m);
		end else begin
			if (blo <= bup)
				r = (alo <= blo) || (aup >= bup);
			else
				r = (alo <= blo) && (aup >= bup);
		end
		return r;
	endfunction

	function automatic logic seg_meets(input logic [W-1:0] alo, input logic [W-1:0] aup,
			input logic [W-1:0] blo, input logic [W-1:0] bup,
			input logic [W-1:0] ma, input logic [W-1:0] mb);
		logic r;
		if (alo <= aup) begin
			if (blo <= bup)
				r = (alo <= bup) && (aup >= blo);
			else
				r = (mb >= alo) && ((alo <= bup) || (aup >= blo));
		end else begin
			if (blo <= bup)
				r = (ma >= blo) && ((alo <= bup) || (aup >= blo));
			else
				r = 1'b1;
		end
		return r;
	endfunction

	// stage 1: load and clamp
	op_t pa_s1, pb_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			pa_s1 <= load_op(query.first_offset, query.first_count,
				query.first_stride_log, query.first_width);
			pb_s1 <= load_op(query.second_offset, query.second_count,
				query.second_stride_log, query.second_width);
		end
	end

	// stage 2: membership terms, contains bounds, overlap operand order
	op_t          pa_s2, pb_s2, r1_s2, r2_s2;
	logic         bad_a_s2, bad_b_s2, fine_s2, cmis_s2, swap_s2, omis_s2;
	logic [W-1:0] q_a_s2, q_b_s2, ub1_s2, top2_s2, gap_s2, limc_s2;
	logic [W-1:0] d1p_s2, d2p_s2, m2s_s2;
	logic [S-1:0] rs_s2;

	op_t          r1_n2, r2_n2;
	logic [W-1:0] t_a, t_b;
	logic         swap_n2;

	always_comb begin
		t_a = (pb_s1.d - pa_s1.disp) & pa_s1.m;
		t_b = (pa_s1.d - pb_s1.disp) & pb_s1.m;
		swap_n2 = pb_s1.s > pa_s1.s;
		r1_n2 = swap_n2 ? pb_s1 : pa_s1;
		r2_n2 = swap_n2 ? pa_s1 : pb_s1;
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			pa_s2 <= pa_s1;
			pb_s2 <= pb_s1;
			bad_a_s2 <= (|(pb_s1.d & ~pa_s1.m)) ||
				(|(t_a & sirt_pkg::low_ones({1'b0, pa_s1.s})));
			bad_b_s2 <= (|(pa_s1.d & ~pb_s1.m)) ||
				(|(t_b & sirt_pkg::low_ones({1'b0, pb_s1.s})));
			q_a_s2 <= t_a >> pa_s1.s;
			q_b_s2 <= t_b >> pb_s1.s;
			fine_s2 <= pb_s1.s < pa_s1.s;
			cmis_s2 <= |((pa_s1.disp - pb_s1.disp) & sirt_pkg::low_ones({1'b0, pa_s1.s}));
			ub1_s2 <= ((pa_s1.i << pa_s1.s) + pa_s1.d) & pa_s1.m;
			top2_s2 <= (pb_s1.i << pb_s1.s) + pb_s1.d;
			gap_s2 <= (pa_s1.m >> pa_s1.s) - pa_s1.i;
			limc_s2 <= sirt_pkg::low_ones({1'b0, pb_s1.s} - {1'b0, pa_s1.s});
			swap_s2 <= swap_n2;
			r1_s2 <= r1_n2;
			r2_s2 <= r2_n2;
			omis_s2 <= |((r2_n2.d - r1_n2.d) & sirt_pkg::low_ones({1'b0, r2_n2.s}));
			d1p_s2 <= r1_n2.d >> r2_n2.s;
			d2p_s2 <= r2_n2.d >> r2_n2.s;
			rs_s2 <= r1_n2.s - r2_n2.s;
			m2s_s2 <= r2_n2.m >> r2_n2.s;
		end
	end

	// stage 3: membership results, wrap tests, first residue alignment
	op_t          pa_s3, r1_s3, r2_s3;
	logic         h_a_s3, fine_s3, cmis_s3, rbad_s3, wrap_s3, gt_s3, kelse_s3;
	logic [W-1:0] ub1_s3, gap_s3, limc_s3, x_s3, hi2_s3, lo2_s3, ub2_s3, ib_s3, d2_s3;
	logic [W-1:0] d1p_s3, d2p_s3, m2s_s3, lowm_s3, rd1_s3, off_s3;
	logic [S-1:0] rs_s3;
	ofl_t         ofl_s3;

	logic         h_a, h_b;
	logic [W-1:0] ub2_n3, lowm_n3, rd1_n3, dl_n3, lob;

	always_comb begin
		h_a = !bad_a_s2 && (q_a_s2 <= pa_s2.cnt);
		h_b = !bad_b_s2 && (q_b_s2 <= pb_s2.cnt);
		ub2_n3 = top2_s2 & pb_s2.m;
		lob = sirt_pkg::low_ones({1'b0, pb_s2.s});
		lowm_n3 = sirt_pkg::low_ones({1'b0, rs_s2});
		rd1_n3 = d1p_s2 & lowm_n3;
		dl_n3 = d2p_s2 & lowm_n3;
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			pa_s3 <= pa_s2;
			ib_s3 <= pb_s2.i;
			d2_s3 <= pb_s2.d;
			h_a_s3 <= h_a;
			fine_s3 <= fine_s2;
			cmis_s3 <= cmis_s2;
			ub1_s3 <= ub1_s2;
			gap_s3 <= gap_s2;
			limc_s3 <= limc_s2;
			rbad_s3 <= (pa_s2.m < pb_s2.m) &&
				((pb_s2.d > pa_s2.m) || (top2_s2 > pa_s2.m) || (ub2_n3 < pb_s2.d));
			x_s3 <= ((ub1_s2 - pb_s2.d) & lob) >> pa_s2.s;
			wrap_s3 <= ub2_n3 < pb_s2.d;
			hi2_s3 <= pb_s2.d | (pb_s2.m & ~lob);
			lo2_s3 <= pb_s2.d & lob;
			ub2_s3 <= ub2_n3;
			r1_s3 <= r1_s2;
			r2_s3 <= r2_s2;
			d1p_s3 <= d1p_s2;
			d2p_s3 <= d2p_s2;
			m2s_s3 <= m2s_s2;
			rs_s3 <= rs_s2;
			lowm_s3 <= lowm_n3;
			rd1_s3 <= rd1_n3;
			gt_s3 <= dl_n3 > rd1_n3;
			off_s3 <= ((lowm_n3 & m2s_s2) + W'(1)) - dl_n3 + rd1_n3;
			kelse_s3 <= ((rd1_n3 - dl_n3) > r2_s2.i) || (|(rd1_n3 & ~m2s_s2));
			// second interval a constant is tested first, then the first
			ofl_s3.early <= (r2_s2.i == '0) || (r1_s2.i == '0);
			ofl_s3.eval <= (r2_s2.i == '0) ? (swap_s2 ? h_b : h_a) : (swap_s2 ? h_a : h_b);
			ofl_s3.mis <= omis_s2;
			ofl_s3.kill <= 1'b0;
		end
	end

	// stage 4: segment cover tests, residue alignment applied
	// the wrapped second set is split at the top of its word; the
	// unwrapped one is compared whole, held separately so both are ready
	logic         izb_s4, h_a_s4, cbad_s4, c1_s4, wrap_s4, cov_b_s4;
	logic         cov_hi_s4, cov_whole_s4;
	op_t          r1_s4;
	logic [W-1:0] m2_s4, d1p_s4, m2s_s4, lowm_s4, rd1_s4, i2n_s4, d2n_s4;
	logic [S-1:0] rs_s4;
	ofl_t         ofl_s4;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			izb_s4 <= ib_s3 == '0;
			h_a_s4 <= h_a_s3;
			cbad_s4 <= fine_s3 || cmis_s3 || rbad_s3;
			c1_s4 <= (gap_s3 <= limc_s3) && ((x_s3 + gap_s3) <= limc_s3);
			wrap_s4 <= wrap_s3;
			cov_hi_s4 <= seg_covers(pa_s3.d, ub1_s3, d2_s3, hi2_s3, pa_s3.m);
			cov_whole_s4 <= seg_covers(pa_s3.d, ub1_s3, d2_s3, ub2_s3, pa_s3.m);
			cov_b_s4 <= seg_covers(pa_s3.d, ub1_s3, lo2_s3, ub2_s3, pa_s3.m);
			r1_s4 <= r1_s3;
			m2_s4 <= r2_s3.m;
			d1p_s4 <= d1p_s3;
			m2s_s4 <= m2s_s3;
			lowm_s4 <= lowm_s3;
			rd1_s4 <= rd1_s3;
			rs_s4 <= rs_s3;
			i2n_s4 <= gt_s3 ? r2_s3.i - off_s3 : r2_s3.i;
			d2n_s4 <= gt_s3 ? (d2p_s3 + off_s3) & m2s_s3 : d2p_s3;
			ofl_s4.early <= ofl_s3.early;
			ofl_s4.eval <= ofl_s3.eval;
			ofl_s4.mis <= ofl_s3.mis;
			ofl_s4.kill <= gt_s3 ? (r2_s3.i < off_s3) : kelse_s3;
		end
	end

	// stage 5: contains decided, tail alignment terms
	logic         contains_s5, adj_s5;
	op_t          r1_s5;
	logic [W-1:0] m2_s5, d1p_s5, m2s_s5, i2n_s5, d2n_s5, off2_s5;
	logic [S-1:0] rs_s5;
	ofl_t         ofl_s5;

	logic         contains_n5;
	logic [W-1:0] tail_n5;

	always_comb begin
		if (izb_s4)
			contains_n5 = h_a_s4;
		else if (cbad_s4)
			contains_n5 = 1'b0;
		else if (c1_s4)
			contains_n5 = 1'b1;
		else if (wrap_s4)
			contains_n5 = cov_hi_s4 && cov_b_s4;
		else
			contains_n5 = cov_whole_s4;
		tail_n5 = (i2n_s4 + d2n_s4) & m2s_s4 & lowm_s4;
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			contains_s5 <= contains_n5;
			adj_s5 <= tail_n5 < rd1_s4;
			off2_s5 <= tail_n5 + (W'(1) << rs_s4) - rd1_s4;
			r1_s5 <= r1_s4;
			m2_s5 <= m2_s4;
			d1p_s5 <= d1p_s4;
			m2s_s5 <= m2s_s4;
			i2n_s5 <= i2n_s4;
			d2n_s5 <= d2n_s4;
			rs_s5 <= rs_s4;
			ofl_s5 <= ofl_s4;
		end
	end

	// stage 6: scale down to the coarser stride
	logic         contains_s6;
	logic [W-1:0] i1_s6, d1q_s6, d2q_s6, i2q_s6, ma_s6, mb_s6;
	ofl_t         ofl_s6;

	logic [W-1:0] i2a_n6;

	always_comb begin
		if (!adj_s5)
			i2a_n6 = i2n_s5;
		else if (i2n_s5 < off2_s5)
			i2a_n6 = '0;
		else
			i2a_n6 = i2n_s5 - off2_s5;
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			contains_s6 <= contains_s5;
			i1_s6 <= r1_s5.i;
			d1q_s6 <= d1p_s5 >> rs_s5;
			d2q_s6 <= d2n_s5 >> rs_s5;
			i2q_s6 <= i2a_n6 >> rs_s5;
			ma_s6 <= r1_s5.m >> r1_s5.s;
			mb_s6 <= m2_s5 >> r1_s5.s;
			ofl_s6 <= ofl_s5;
		end
	end

	// stage 7: segment upper bounds
	logic         contains_s7;
	logic [W-1:0] d1q_s7, d2q_s7, aup_s7, bup_s7, ma_s7, mb_s7;
	ofl_t         ofl_s7;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			contains_s7 <= contains_s6;
			d1q_s7 <= d1q_s6;
			d2q_s7 <= d2q_s6;
			aup_s7 <= (i1_s6 + d1q_s6) & ma_s6;
			bup_s7 <= (i2q_s6 + d2q_s6) & mb_s6;
			ma_s7 <= ma_s6;
			mb_s7 <= mb_s6;
			ofl_s7 <= ofl_s6;
		end
	end

	// stage 8: result register
	sirt_pkg::result_t result_s8;
	logic              overlaps_n8;

	always_comb begin
		if (ofl_s7.early)
			overlaps_n8 = ofl_s7.eval;
		else if (ofl_s7.mis || ofl_s7.kill)
			overlaps_n8 = 1'b0;
		else
			overlaps_n8 = seg_meets(d1q_s7, aup_s7, d2q_s7, bup_s7, ma_s7, mb_s7);
	end

	always_ff @(posedge clk) begin
		if (en[8]) begin
			result_s8.contains <= contains_s7;
			result_s8.overlaps <= overlaps_n8;
		end
	end

	assign result = result_s8;

endmodule
`default_nettype wire

@@ sv/strided_interval_relation_test.sv @@
// top level of the strided interval relation test: handshake and valid pipeline
`default_nettype none
// channel   | valid        | stall         | payload
// query in  | query_valid  | query_stall   | query  (two strided intervals)
// result out| result_valid | result_stall  | result (contains, overlaps)
//
// eight register stages from query transfer to result; one query a cycle
// while no stall holds the pipeline; the stage count is set by the overlap path
// (alignment, tail trim, rescale, segment bounds, segment compare)
// each stage holds while the stage ahead is full and cannot move, so a
// stall fills bubbles first and nothing is lost or repeated
// reset clears the valid bits only; no clearing pass is needed
module strided_interval_relation_test (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             query_valid,
	output logic                  query_stall,
	input  wire sirt_pkg::query_t query,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output sirt_pkg::result_t     result
);

	localparam int N = sirt_pkg::NUM_STAGES;

	logic [N:1] vld_q;
	logic [N:1] en;

	// a stage may load when it is empty or when its content moves on
	always_comb begin
		en[N] = !vld_q[N] || !result_stall;
		for (int k = N - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1])
				vld_q[1] <= query_valid;
			for (int k = 2; k <= N; k++) begin
				if (en[k])
					vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign query_stall  = !en[1];
	assign result_valid = vld_q[N];

	// datapath
	sirt_core u_core (
		.clk    (clk),
		.en     (en),
		.query  (query),
		.result (result)
	);

endmodule
`default_nettype wire

@@ bench/strided_interval_relation_test_test.sv @@
// testbench for the strided interval relation test: random and directed queries, scoreboard check
`default_nettype none
module strided_interval_relation_test_test;

	// one operand after loading: masked base, highest step, mask, stride exponent
	typedef struct {
		bit [63:0]   base;
		bit [63:0]   steps;
		bit [63:0]   mask;
		int unsigned shift;
	} interval_t;

	class relation_board;
		sirt_pkg::result_t pending[$];
		int                errors;

		static function bit [63:0] ones_below(int unsigned n);
			return (n >= 64) ? '1 : (64'd1 << n) - 64'd1;
		endfunction

		static function interval_t load(bit [63:0] off, bit [63:0] cnt, bit [5:0] slog,
			bit [6:0] w);
			interval_t iv;
			int unsigned wd;
			wd = (w > 64) ? 64 : w;
			iv.mask  = ones_below(wd);
			iv.base  = off & iv.mask;
			iv.steps = cnt;
			iv.shift = slog;
			return iv;
		endfunction

		static function bit member_of(interval_t iv, bit [63:0] v);
			if (v & ~iv.mask)
				return 0;
			v = (v - iv.base) & iv.mask;
			if (v & ones_below(iv.shift))
				return 0;
			v = v >> iv.shift;
			return v <= iv.steps;
		endfunction

		// a count beyond the width clamps to the top step and the base keeps only low bits
		static function void clamp(interval_t iv, output bit [63:0] d, output bit [63:0] i);
			d = iv.base & iv.mask;
			i = iv.steps;
			if (iv.steps > (iv.mask >> iv.shift)) begin
				i = iv.mask >> iv.shift;
				d &= ones_below(iv.shift);
			end
		endfunction

		static function bit span_covers(bit [63:0] alo, aup, blo, bup, m);
			if (alo <= aup) begin
				if (blo <= bup)
					return alo <= blo && aup >= bup;
				return alo == 0 && aup == m;
			end
			if (blo <= bup)
				return alo <= blo || aup >= bup;
			return alo <= blo && aup >= bup;
		endfunction

		static function bit span_meets(bit [63:0] alo, aup, blo, bup, ma, mb);
			if (alo <= aup) begin
				if (blo <= bup)
					return alo <= bup && aup >= blo;
				return mb >= alo && (alo <= bup || aup >= blo);
			end
			if (blo <= bup)
				return ma >= blo && (alo <= bup || aup >= blo);
			return 1;
		endfunction

		static function bit includes(interval_t r1, interval_t r2);
			bit [63:0] d1, i1, d2, i2, ub1, ub2, top2, gap, lim;
			clamp(r1, d1, i1);
			clamp(r2, d2, i2);
			if (i2 == 0)
				return member_of(r1, d2);
			if (r2.shift < r1.shift)
				return 0;
			if ((r1.base - r2.base) & ones_below(r1.shift))
				return 0;
			ub1  = ((i1 << r1.shift) + d1) & r1.mask;
			top2 = (i2 << r2.shift) + d2;
			ub2  = top2 & r2.mask;
			if (r1.mask < r2.mask && (d2 > r1.mask || top2 > r1.mask || ub2 < d2))
				return 0;
			gap = (r1.mask >> r1.shift) - i1;
			lim = ones_below(r2.shift - r1.shift);
			if (gap <= lim && ((((ub1 - d2) & ones_below(r2.shift)) >> r1.shift) + gap) <= lim)
				return 1;
			if (ub2 < d2)
				return span_covers(d1, ub1, d2, d2 | (r2.mask & ~ones_below(r2.shift)), r1.mask)
					&& span_covers(d1, ub1, d2 & ones_below(r2.shift), ub2, r1.mask);
			return span_covers(d1, ub1, d2, ub2, r1.mask);
		endfunction

		static function bit intersects(interval_t a, interval_t b);
			interval_t r1, r2;
			bit [63:0] d1, i1, d2, i2, rd1, lowm, m2s, tail, off;
			int unsigned rs;
			r1 = a;
			r2 = b;
			// coarser stride goes first
			if (b.shift > a.shift) begin
				r1 = b;
				r2 = a;
			end
			clamp(r1, d1, i1);
			clamp(r2, d2, i2);
			if (i2 == 0)
				return member_of(r1, d2);
			if (i1 == 0)
				return member_of(r2, d1);
			if ((d2 - d1) & ones_below(r2.shift))
				return 0;
			d1   = d1 >> r2.shift;
			d2   = d2 >> r2.shift;
			rs   = r1.shift - r2.shift;
			lowm = ones_below(rs);
			rd1  = d1 & lowm;
			m2s  = r2.mask >> r2.shift;
			// align the finer interval to the phase of the coarser one
			if ((d2 & lowm) > rd1) begin
				off = ((lowm & m2s) + 64'd1) - (d2 & lowm) + rd1;
				if (i2 < off)
					return 0;
				i2 -= off;
				d2 = (d2 + off) & m2s;
			end else if ((rd1 - (d2 & lowm)) > i2 || (rd1 & ~m2s)) begin
				return 0;
			end
			// trim the tail back to the same phase
			tail = (i2 + d2) & m2s & lowm;
			if (tail < rd1) begin
				off = tail + (64'd1 << rs) - rd1;
				i2 = (i2 < off) ? 64'd0 : i2 - off;
			end
			d1 = d1 >> rs;
			d2 = d2 >> rs;
			i2 = i2 >> rs;
			return span_meets(d1, (i1 + d1) & (r1.mask >> r1.shift),
				d2, (i2 + d2) & (r2.mask >> r1.shift),
				r1.mask >> r1.shift, r2.mask >> r1.shift);
		endfunction

		function void note(sirt_pkg::query_t q);
			interval_t x, y;
			sirt_pkg::result_t r;
			x = load(q.first_offset, q.first_count, q.first_stride_log, q.first_width);
			y = load(q.second_offset, q.second_count, q.second_stride_log, q.second_width);
			r.contains = includes(x, y);
			r.overlaps = intersects(x, y);
			pending.push_back(r);
		endfunction

		function void check(sirt_pkg::result_t got);
			sirt_pkg::result_t want;
			if (pending.size() == 0) begin
				$display("%0t: result %b with nothing expected", $realtime, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.contains !== want.contains) begin
				$display("%0t: contains expected %b actual %b", $realtime, want.contains,
					got.contains);
				errors++;
			end
			if (got.overlaps !== want.overlaps) begin
				$display("%0t: overlaps expected %b actual %b", $realtime, want.overlaps,
					got.overlaps);
				errors++;
			end
		endfunction
	endclass

	logic              clk = 0;
	logic              arst_n = 0;
	logic              query_valid = 0;
	logic              query_stall;
	sirt_pkg::query_t  query = '0;
	logic              result_valid;
	logic              result_stall = 0;
	sirt_pkg::result_t result;

	relation_board board = new();
	int  idle_in, idle_out;
	bit  query_taken;

	strided_interval_relation_test i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.query_valid(query_valid),
		.query_stall(query_stall),
		.query(query),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always #2 clk = ~clk;

	// both channels sampled at the rising edge; a transfer is valid and not stalled
	always @(posedge clk) begin
		query_taken = query_valid && !query_stall;
		if (query_taken)
			board.note(query);
		if (result_valid && !result_stall)
			board.check(result);
	end

	// receiver stalls at random, changed at the falling edge
	always @(negedge clk) begin
		if (arst_n)
			result_stall <= ($urandom_range(99) < idle_out);
	end

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_query(input sirt_pkg::query_t q);
		while ($urandom_range(99) < idle_in) begin
			query_valid <= 0;
			@(negedge clk);
		end
		query_valid <= 1;
		query <= q;
		do @(negedge clk); while (!query_taken);
	endtask

	task automatic send_pair(input bit [63:0] o1, c1, input bit [5:0] s1, input bit [6:0] w1,
		input bit [63:0] o2, c2, input bit [5:0] s2, input bit [6:0] w2);
		sirt_pkg::query_t q;
		q.first_offset      = o1;
		q.first_count       = c1;
		q.first_stride_log  = s1;
		q.first_width       = w1;
		q.second_offset     = o2;
		q.second_count      = c2;
		q.second_stride_log = s2;
		q.second_width      = w2;
		send_query(q);
	endtask

	function automatic bit [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic bit [63:0] rand_count();
		case ($urandom_range(9))
			0, 1, 2: return 64'($urandom_range(0, 3));
			3, 4, 5: return 64'($urandom_range(0, 40));
			6:       return '1;
			default: return rand64();
		endcase
	endfunction

	// mostly related operands so that inclusion and intersection are reached
	function automatic sirt_pkg::query_t random_query();
		sirt_pkg::query_t q;
		int unsigned w;
		case ($urandom_range(9))
			0:       w = $urandom_range(0, 127);
			1:       w = 64;
			2, 3:    w = $urandom_range(1, 8);
			default: w = $urandom_range(1, 64);
		endcase
		q.first_width      = 7'(w);
		q.first_stride_log = 6'(($urandom_range(4) == 0) ? $urandom_range(0, 63)
			: $urandom_range(0, 4));
		q.first_count      = rand_count();
		q.first_offset     = rand64();
		if ($urandom_range(9) < 6) begin
			// second built from the first: mostly same width, shifted base, equal or coarser stride unless the exponent wraps
			q.second_width      = 7'(($urandom_range(4) == 0) ? $urandom_range(1, 64) : w);
			q.second_stride_log = 6'(q.first_stride_log + $urandom_range(0, 2));
			q.second_offset     = q.first_offset
				+ (64'($urandom_range(0, 30)) << q.first_stride_log);
			q.second_count      = ($urandom_range(1) == 0) ? 64'($urandom_range(0, 12))
				: rand_count();
		end else begin
			q.second_width      = 7'($urandom_range(0, 127));
			q.second_stride_log = 6'($urandom_range(0, 63));
			q.second_offset     = rand64();
			q.second_count      = rand_count();
		end
		return q;
	endfunction

	initial begin
		idle_in  = 0;
		idle_out = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: extremes, constants, zero and wide widths, finer second stride
		send_pair('1, '1, 6'd63, 7'd127, '1, '1, 6'd63, 7'd127);
		send_pair('0, '0, 6'd0, 7'd0, '0, '0, 6'd0, 7'd0);
		send_pair('0, '1, 6'd0, 7'd64, 64'd5, 64'd9, 6'd0, 7'd64);
		send_pair(64'd3, 64'd0, 6'd0, 7'd8, 64'd3, 64'd0, 6'd0, 7'd8);
		send_pair(64'd3, 64'd0, 6'd0, 7'd8, 64'd4, 64'd0, 6'd0, 7'd8);
		send_pair(64'h1ff, 64'd3, 6'd1, 7'd8, 64'hff, 64'd2, 6'd1, 7'd8);
		send_pair(64'd0, 64'd10, 6'd2, 7'd8, 64'd4, 64'd3, 6'd1, 7'd8);
		send_pair(64'd0, 64'd10, 6'd1, 7'd8, 64'd4, 64'd3, 6'd2, 7'd8);
		send_pair(64'd0, 64'd10, 6'd1, 7'd8, 64'd6, 64'd0, 6'd0, 7'd8);
		send_pair(64'd250, 64'd10, 6'd0, 7'd8, 64'd252, 64'd5, 6'd0, 7'd8);
		send_pair(64'd250, 64'd10, 6'd0, 7'd8, 64'd2, 64'd3, 6'd0, 7'd8);
		send_pair(64'd1, 64'd5, 6'd9, 7'd8, 64'd1, 64'd5, 6'd9, 7'd8);
		send_pair(64'd0, 64'd3, 6'd0, 7'd4, 64'd0, 64'd3, 6'd0, 7'd8);
		send_pair(64'd0, 64'd300, 6'd0, 7'd8, 64'd0, 64'd300, 6'd0, 7'd4);
		send_pair(64'h8000_0000_0000_0000, 64'd7, 6'd60, 7'd100, 64'd0, 64'd1, 6'd63, 7'd64);
		send_pair('1, 64'd2, 6'd0, 7'd1, 64'd1, 64'd0, 6'd0, 7'd1);
		send_pair(64'd7, 64'd100, 6'd2, 7'd64, 64'd11, 64'd4, 6'd3, 7'd64);
		send_pair(64'hfffffff0, 64'd40, 6'd0, 7'd32, 64'd4, 64'd6, 6'd0, 7'd32);

		// random phases: receiver stalls more, then sender idles more, then no idling
		for (int ph = 0; ph < 3; ph++) begin
			idle_in  = (ph == 0) ? 31 : (ph == 1) ? 75 : 0;
			idle_out = (ph == 0) ? 75 : (ph == 1) ? 31 : 0;
			for (int n = 0; n < 230; n++)
				send_query(random_query());
		end
		query_valid <= 0;

		while (board.pending.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (board.errors == 0)
			$display("strided_interval_relation_test_test passed");
		else
			$display("strided_interval_relation_test_test failed");
		$finish;
	end

	// guard against a hang
	initial begin
		#2000000;
		$display("strided_interval_relation_test_test failed");
		$finish;
	end

endmodule
`default_nettype wire
